/* design/aes128_block_cipher_defines.svh */
// assertion macros for the aes-128 block cipher
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTH
`define AES_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AES_ASSERT_RST(lbl, prop, msg) lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AES_ASSERT(lbl, prop, msg)
`define AES_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* design/aes_pkg.sv */
// ----------------------------------------------------------------------------
// aes_pkg
// types, constants and byte functions shared by the aes-128 block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned KeyWords  = 4;
  localparam int unsigned TotalWords = 44;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  localparam logic KindEnc = 1'b0;
  localparam logic KindDec = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  typedef logic [127:0] state_t;

  // key schedule status towards the cipher core
  typedef struct packed {
    logic busy;
    logic done;
  } ks_status_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

/* design/aes_ram.sv */
// ----------------------------------------------------------------------------
// aes_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write, and registered read of the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* design/aes_keyexp.sv */
// ----------------------------------------------------------------------------
// aes_keyexp
// expands the key into 44 round-key words, one word a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_cipher_defines.svh"
module aes_keyexp import aes_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] key,
  output logic              we,
  output logic [5:0]        waddr,
  output logic [31:0]       wdata,
  output ks_status_t        status
);
  // sliding window of the last four words
  logic [127:0] win_r, win_nxt;
  logic [5:0]   idx_r, idx_nxt;
  logic         busy_r, busy_nxt;
  logic [31:0]  t, nw;
  logic [3:0]   rnd;

  always_comb begin
    rnd = idx_r[5:2];
    t = win_r[31:0];
    if (idx_r[1:0] == 2'd0) begin
      t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
          ^ {rcon(rnd), 24'h0};
    end
    nw = win_r[127:96] ^ t;
  end

  // sequencer: the first four words are the key itself
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    win_nxt  = win_r;
    we    = 1'b0;
    waddr = idx_r;
    wdata = nw;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = 6'd0;
      win_nxt  = key;
    end else if (busy_r) begin
      we = 1'b1;
      idx_nxt = idx_r + 6'd1;
      if (idx_r < 6'(KeyWords)) begin
        wdata = win_r[127 - 32*idx_r[1:0] -: 32];
      end else begin
        win_nxt = {win_r[95:0], nw};
      end
      if (idx_r == 6'(TotalWords - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= 6'd0;
      win_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      win_r  <= win_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = busy_r && (idx_r == 6'(TotalWords - 1));

  `AES_ASSERT(a_idx_range, busy_r |-> idx_r < 6'(TotalWords), "key index out of range")
  `AES_ASSERT(a_done_ends, status.done && !start |=> !busy_r, "expansion did not stop")
  `AES_ASSERT(a_we_busy, we |-> busy_r, "write while idle")
endmodule
`default_nettype wire

/* design/aes128_block_cipher.sv */
// ----------------------------------------------------------------------------
// aes128_block_cipher: aes-128 ecb core, one round step at a time, shared round unit
// each item takes 11 round steps, each step four key-word reads (S_RD) then one round (S_RUN)
// a new item is taken only in S_IDLE, after the last result has been taken from S_OUT
// reset: key clears to zero and is expanded into all 44 words, no item taken meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_cipher_defines.svh"
module aes128_block_cipher import aes_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_item_t          out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]   cfg_data
);
  typedef enum logic [2:0] {S_IDLE, S_RD, S_RUN, S_OUT} st_t;
  st_t st_r;

  logic [63:0] khi_r, klo_r;
  logic        cfg_we;
  ks_status_t  ks;
  logic        ks_we;
  logic [5:0]  ks_addr, ram_addr;
  logic [31:0] ks_wdata, ram_q;
  logic [127:0] st_v_r, rk_r, rk_v;
  logic        dec_r;
  logic [3:0]  rnd_r;
  logic [1:0]  col_r;
  logic [127:0] rnd_out;
  logic [5:0]  word_addr;
  logic        last_r;

  assign cfg_ready = (st_r == S_IDLE);
  assign cfg_we = cfg_valid && cfg_ready;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      khi_r <= '0;
      klo_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegKeyHigh) khi_r <= cfg_data;
      if (cfg_index == RegKeyLow)  klo_r <= cfg_data;
    end
  end

  aes_keyexp u_keyexp (
    .clk(clk), .rst_n(rst_n), .start(cfg_we), .key({cfg_index == RegKeyHigh ? cfg_data : khi_r,
      cfg_index == RegKeyLow ? cfg_data : klo_r}),
    .we(ks_we), .waddr(ks_addr), .wdata(ks_wdata), .status(ks)
  );

  // round key of round r is words 4r..4r+3
  assign word_addr = {rnd_r, col_r};
  assign ram_addr  = ks.busy ? ks_addr : word_addr;

  aes_ram #(.Width(32), .Depth(TotalWords)) u_ram (
    .clk(clk), .we(ks_we), .addr(ram_addr), .wdata(ks_wdata), .rdata(ram_q)
  );

  // full round key: three collected words plus the one on the ram output
  assign rk_v = {rk_r[95:0], ram_q};

  // shared round unit
  always_comb begin
    logic [7:0] b [16];
    logic [7:0] s [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1;
    for (int i = 0; i < 16; i++) b[i] = st_v_r[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (!dec_r) s[r + 4*c] = sbox(b[r + 4*((c + r) % 4)]);
        else s[r + 4*c] = inv_sbox(b[r + 4*((c - r + 4) % 4)]);
      end
    end
    // encrypt: sub/shift then mix; decrypt: add-key then inverse mix
    for (int i = 0; i < 16; i++) m[i] = dec_r ? (b[i] ^ rk_v[127 - 8*i -: 8]) : s[i];
    for (int c = 0; c < 4; c++) begin
      a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
      x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
      y0 = xt(x0 ^ x2); y1 = xt(x1 ^ x3);
      if (!dec_r) begin
        m[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
        m[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
        m[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
        m[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      end else if (!last_r && rnd_r != 4'(NumRounds)) begin
        // inverse mix as pre-multiply then forward mix
        a0 = a0 ^ y0; a1 = a1 ^ y1; a2 = a2 ^ y0; a3 = a3 ^ y1;
        x0 = xt(a0); x1 = xt(a1); x2 = xt(a2); x3 = xt(a3);
        m[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
        m[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
        m[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
        m[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (!dec_r) begin
        rnd_out[127 - 8*i -: 8] = (last_r ? s[i] : m[i]) ^ rk_v[127 - 8*i -: 8];
      end else begin
        // decrypt round: key add, inverse mix (not in round 10), inverse shift, inverse sub; last step is key add only
        rnd_out[127 - 8*i -: 8] = m[i];
      end
    end
    if (dec_r) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          rnd_out[127 - 8*(r + 4*c) -: 8] = inv_sbox(m[r + 4*((c - r + 4) % 4)]);
      if (last_r) rnd_out = st_v_r ^ rk_v;
    end
  end

  // sequencer: four key words per round, then one round step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      col_r <= '0;
      rnd_r <= '0;
      dec_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (in_valid && !ks.busy && !cfg_valid) begin
            dec_r  <= in_data.kind;
            st_v_r <= {in_data.block_hi, in_data.block_lo};
            rnd_r  <= in_data.kind ? 4'(NumRounds) : 4'd0;
            col_r  <= '0;
            last_r <= 1'b0;
            st_r   <= S_RD;
          end
        end
        S_RD: begin
          // ram read is registered, so the data lags the address
          col_r <= col_r + 2'd1;
          if (col_r == 2'd3) begin
            st_r <= S_RUN;
          end
        end
        S_RUN: begin
          // first encrypt step is the bare key add
          if (!dec_r && rnd_r == 4'd0) begin
            st_v_r <= st_v_r ^ rk_v;
          end else begin
            st_v_r <= rnd_out;
          end
          if (last_r) begin
            st_r <= S_OUT;
          end else begin
            st_r <= S_RD;
            rnd_r <= dec_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
            last_r <= dec_r ? (rnd_r == 4'd1) : (rnd_r == 4'(NumRounds - 1));
          end
        end
        S_OUT: begin
          if (!out_stall) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // key word collection, one ram word a cycle
  always_ff @(posedge clk) begin
    if (st_r == S_RD || st_r == S_RUN) begin
      rk_r <= {rk_r[95:0], ram_q};
    end
  end

  assign in_stall  = (st_r != S_IDLE) || ks.busy || cfg_valid;
  assign out_valid = (st_r == S_OUT);
  assign out_data  = {st_v_r[127:64], st_v_r[63:0]};

  `AES_ASSERT(a_no_accept_busy, ks.busy |-> in_stall, "item taken during key expansion")
  `AES_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result lost")
  `AES_ASSERT(a_cfg_idle, cfg_ready |-> !out_valid, "config while busy")
endmodule
`default_nettype wire
